[sv/etp_pkg.sv]
// ----------------------------------------------------------------------------
// etp_pkg
// Shared types and constants for the envelope-triggered pitch ramp.
// ----------------------------------------------------------------------------
`default_nettype none

package etp_pkg;

  localparam int ENV_SHIFT = 8;

  localparam int SAMPLE_W = 24;
  localparam int ENV_W    = 25;
  localparam int TUNE_W   = 26;
  localparam int WAMT_W   = 17;
  localparam int RATIO_W  = 18;
  localparam int DELTA_W  = 19;
  localparam int PROD_W   = TUNE_W + 1 + DELTA_W;
  localparam int CFG_W    = 24;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_WHAMMY_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_ZERO = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_LEVEL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_STEP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_STEP    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WHAMMY_AMOUNT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_RATIO   = 3'd6;

  localparam logic [23:0]        TRIGGER_RST = 24'd838861;
  localparam logic [23:0]        ATTACK_RST  = 24'd2000;
  localparam logic [23:0]        DECAY_RST   = 24'd2000;
  localparam logic [RATIO_W-1:0] RANGE_RST   = 18'd65536;
  localparam logic [RATIO_W-1:0] UNITY_Q16   = 18'd65536;
  localparam logic [RATIO_W-1:0] RATIO_MAX   = 18'd262143;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_UP   = 2'd1,
    PH_HOLD = 2'd2,
    PH_DOWN = 2'd3
  } ph_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENV,
    ST_PHASE,
    ST_MUL1,
    ST_MUL2,
    ST_DONE
  } st_t;

  typedef struct packed {
    logic env_en;
    logic ph_en;
    logic mul_en;
    logic mul_sel;
  } ctl_t;

endpackage

`default_nettype wire

[sv/etp_in_if.sv]
// ----------------------------------------------------------------------------
// etp_in_if
// Input channel: one stereo sample pair per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface etp_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [etp_pkg::SAMPLE_W-1:0] left_sample;
  logic signed [etp_pkg::SAMPLE_W-1:0] right_sample;

  modport source (output valid, output left_sample, output right_sample, input ready);
  modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

`default_nettype wire

[sv/etp_out_if.sv]
// ----------------------------------------------------------------------------
// etp_out_if
// Result channel: mono sample, pitch ratio, phase and envelope per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface etp_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [etp_pkg::SAMPLE_W-1:0] mono_sample;
  logic        [etp_pkg::RATIO_W-1:0]  pitch_ratio;
  logic        [1:0]                   ramp_phase;
  logic        [etp_pkg::SAMPLE_W-1:0] envelope_level;

  modport source (output valid, output mono_sample, output pitch_ratio,
                  output ramp_phase, output envelope_level, input ready);
  modport sink   (input valid, input mono_sample, input pitch_ratio,
                  input ramp_phase, input envelope_level, output ready);
endinterface

`default_nettype wire

[sv/etp_trk.sv]
// ----------------------------------------------------------------------------
// etp_trk
// Envelope follower and four-phase tune ramp, one step per enable.
// ----------------------------------------------------------------------------
`default_nettype none

module etp_trk #(
  parameter int ENV_SHIFT = etp_pkg::ENV_SHIFT
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire etp_pkg::ctl_t                 ctl,
  input  wire logic [etp_pkg::ENV_W-1:0]     sum_in,
  input  wire logic [23:0]                   trig,
  input  wire logic [23:0]                   atk,
  input  wire logic [23:0]                   dcy,
  output logic      [etp_pkg::TUNE_W-1:0]    tune,
  output etp_pkg::ph_t                       phase,
  output logic      [etp_pkg::SAMPLE_W-1:0]  env_level
);

  logic [etp_pkg::ENV_W-1:0]  env_r, env_nxt;
  logic [etp_pkg::TUNE_W-1:0] tune_r, tune_nxt;
  etp_pkg::ph_t               ph_r, ph_nxt;

  logic [etp_pkg::ENV_W-1:0]  diff;
  logic [23:0]                tz;
  logic [23:0]                td;
  logic [25:0]                t3;
  logic signed [etp_pkg::TUNE_W:0] tn;
  etp_pkg::ph_t               ph;

  assign diff = env_r - sum_in;
  assign tz   = trig >> 1;
  assign t3   = {2'b00, trig} + {1'b0, trig, 1'b0};
  assign td   = t3[25:2];

  always_comb begin
    env_nxt = env_r;
    if (ctl.env_en) begin
      if (sum_in > env_r) begin
        env_nxt = sum_in;
      end else begin
        env_nxt = env_r - (diff >> ENV_SHIFT);
      end
    end
  end

  // Phase cascade, all transitions within one sample
  always_comb begin
    ph = ph_r;
    tn = $signed({1'b0, tune_r});
    if (env_r <= {1'b0, tz}) begin
      ph = etp_pkg::PH_IDLE;
      tn = '0;
    end
    if (ph == etp_pkg::PH_IDLE && env_r >= {1'b0, trig}) begin
      ph = etp_pkg::PH_UP;
    end
    if (ph == etp_pkg::PH_UP) begin
      tn = tn + $signed({3'b000, atk});
      if (tn >= $signed(27'd16777216)) begin
        ph = etp_pkg::PH_HOLD;
      end
    end
    if (ph == etp_pkg::PH_HOLD && env_r < {1'b0, td}) begin
      ph = etp_pkg::PH_DOWN;
    end
    if (ph == etp_pkg::PH_DOWN) begin
      tn = tn - $signed({3'b000, dcy});
      if (tn <= 0) begin
        tn = '0;
        ph = etp_pkg::PH_IDLE;
      end
    end
    ph_nxt   = ctl.ph_en ? ph : ph_r;
    tune_nxt = ctl.ph_en ? tn[etp_pkg::TUNE_W-1:0] : tune_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      env_r  <= '0;
      tune_r <= '0;
      ph_r   <= etp_pkg::PH_IDLE;
    end else begin
      env_r  <= env_nxt;
      tune_r <= tune_nxt;
      ph_r   <= ph_nxt;
    end
  end

  assign tune      = tune_r;
  assign phase     = ph_r;
  assign env_level = env_r[etp_pkg::ENV_W-1] ? '1 : env_r[etp_pkg::SAMPLE_W-1:0];

endmodule

`default_nettype wire

[sv/etp_mul.sv]
// ----------------------------------------------------------------------------
// etp_mul
// Shared signed multiplier with registered product, two passes per item.
// ----------------------------------------------------------------------------
`default_nettype none

module etp_mul (
  input  wire logic                               clk,
  input  wire etp_pkg::ctl_t                      ctl,
  input  wire logic [etp_pkg::TUNE_W-1:0]         tune,
  input  wire logic [etp_pkg::WAMT_W-1:0]         wamt,
  input  wire logic [etp_pkg::TUNE_W-1:0]         use_val,
  input  wire logic signed [etp_pkg::DELTA_W-1:0] delta,
  output logic signed [etp_pkg::PROD_W-1:0]       prod
);

  logic signed [etp_pkg::TUNE_W:0]    op_a;
  logic signed [etp_pkg::DELTA_W-1:0] op_b;
  logic signed [etp_pkg::PROD_W-1:0]  prod_r;

  // pass 0: tune * whammy amount, pass 1: use * (range - 1.0)
  always_comb begin
    if (ctl.mul_sel) begin
      op_a = $signed({1'b0, use_val});
      op_b = delta;
    end else begin
      op_a = $signed({1'b0, tune});
      op_b = $signed({{(etp_pkg::DELTA_W-etp_pkg::WAMT_W){1'b0}}, wamt});
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= op_a * op_b;
    end
  end

  assign prod = prod_r;

endmodule

`default_nettype wire

[sv/envelope_triggered_pitch_ramp_unit.sv]
// ----------------------------------------------------------------------------
// envelope_triggered_pitch_ramp_unit
// Stereo-to-mono front end with envelope-triggered pitch ratio ramp.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  in_ch   | in  | valid/ready        | left_sample, right_sample
//  out_ch  | out | valid/ready        | mono_sample, pitch_ratio, ramp_phase,
//          |     |                    | envelope_level
//  cfg_*   | in  | cfg_we             | cfg_index, cfg_wdata
//
//  Items are taken one at a time: the accept step, then envelope, phase,
//  two passes through the shared multiplier and rounding.
//  Reset restores the configuration defaults, idles sequencer and tracker, empties the output.
//  A result waits in the output register; the next item is accepted
//  meanwhile, and the sequencer waits in its last step if it is still full.
// ----------------------------------------------------------------------------
`default_nettype none

module envelope_triggered_pitch_ramp_unit #(
  parameter int ENV_SHIFT = etp_pkg::ENV_SHIFT
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  etp_in_if.sink                                 in_ch,
  etp_out_if.source                              out_ch,
  input  wire logic                              cfg_we,
  input  wire logic [etp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [etp_pkg::CFG_W-1:0]         cfg_wdata
);

  logic                         whammy_mode_r;
  logic                         interval_zero_r;
  logic [23:0]                  trigger_level_r;
  logic [23:0]                  attack_step_r;
  logic [23:0]                  decay_step_r;
  logic [etp_pkg::WAMT_W-1:0]   whammy_amount_r;
  logic [etp_pkg::RATIO_W-1:0]  range_ratio_r;

  etp_pkg::st_t st_r, st_nxt;
  etp_pkg::ctl_t ctl;
  logic in_ready;
  logic out_load;

  logic [etp_pkg::ENV_W-1:0]    sum_r;
  logic [etp_pkg::SAMPLE_W-1:0] mono_r;
  logic [etp_pkg::SAMPLE_W-1:0] abs_l, abs_r;
  logic [etp_pkg::ENV_W-1:0]    pair_sum;
  logic [etp_pkg::SAMPLE_W:0]   pair_mono;

  logic [etp_pkg::TUNE_W-1:0]          tune;
  etp_pkg::ph_t                        phase;
  logic [etp_pkg::SAMPLE_W-1:0]        env_level;
  logic [etp_pkg::TUNE_W-1:0]          use_val;
  logic signed [etp_pkg::DELTA_W-1:0]  delta;
  logic signed [etp_pkg::PROD_W-1:0]   prod;

  logic [etp_pkg::PROD_W-1:0]   mag;
  logic [etp_pkg::PROD_W-1:0]   mag_rnd;
  logic [21:0]                  q;
  logic signed [23:0]           ratio;
  logic [etp_pkg::RATIO_W-1:0]  ratio_sat;

  logic                          out_valid_r;
  logic [etp_pkg::SAMPLE_W-1:0]  out_mono_r;
  logic [etp_pkg::RATIO_W-1:0]   out_ratio_r;
  logic [1:0]                    out_phase_r;
  logic [etp_pkg::SAMPLE_W-1:0]  out_env_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      whammy_mode_r   <= 1'b0;
      interval_zero_r <= 1'b0;
      trigger_level_r <= etp_pkg::TRIGGER_RST;
      attack_step_r   <= etp_pkg::ATTACK_RST;
      decay_step_r    <= etp_pkg::DECAY_RST;
      whammy_amount_r <= '0;
      range_ratio_r   <= etp_pkg::RANGE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        etp_pkg::CFG_WHAMMY_MODE:   whammy_mode_r   <= cfg_wdata[0];
        etp_pkg::CFG_INTERVAL_ZERO: interval_zero_r <= cfg_wdata[0];
        etp_pkg::CFG_TRIGGER_LEVEL: trigger_level_r <= cfg_wdata[23:0];
        etp_pkg::CFG_ATTACK_STEP:   attack_step_r   <= cfg_wdata[23:0];
        etp_pkg::CFG_DECAY_STEP:    decay_step_r    <= cfg_wdata[23:0];
        etp_pkg::CFG_WHAMMY_AMOUNT: whammy_amount_r <= cfg_wdata[etp_pkg::WAMT_W-1:0];
        etp_pkg::CFG_RANGE_RATIO:   range_ratio_r   <= cfg_wdata[etp_pkg::RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      etp_pkg::ST_IDLE:  if (in_ch.valid) st_nxt = etp_pkg::ST_ENV;
      etp_pkg::ST_ENV:   st_nxt = etp_pkg::ST_PHASE;
      etp_pkg::ST_PHASE: st_nxt = etp_pkg::ST_MUL1;
      etp_pkg::ST_MUL1:  st_nxt = etp_pkg::ST_MUL2;
      etp_pkg::ST_MUL2:  st_nxt = etp_pkg::ST_DONE;
      etp_pkg::ST_DONE:  if (!out_valid_r || out_ch.ready) st_nxt = etp_pkg::ST_IDLE;
      default:           st_nxt = etp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl      = '0;
    in_ready = 1'b0;
    out_load = 1'b0;
    unique case (st_r)
      etp_pkg::ST_IDLE:  in_ready = 1'b1;
      etp_pkg::ST_ENV:   ctl.env_en = !whammy_mode_r;
      etp_pkg::ST_PHASE: ctl.ph_en = !whammy_mode_r;
      etp_pkg::ST_MUL1:  ctl.mul_en = 1'b1;
      etp_pkg::ST_MUL2: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = 1'b1;
      end
      etp_pkg::ST_DONE:  out_load = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= etp_pkg::ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  assign in_ch.ready = in_ready;

  // front end
  assign abs_l    = in_ch.left_sample[23]  ? (~in_ch.left_sample + 24'd1)
                                           : in_ch.left_sample;
  assign abs_r    = in_ch.right_sample[23] ? (~in_ch.right_sample + 24'd1)
                                           : in_ch.right_sample;
  assign pair_sum = {1'b0, abs_l} + {1'b0, abs_r};
  assign pair_mono = {in_ch.left_sample[23], in_ch.left_sample}
                   + {in_ch.right_sample[23], in_ch.right_sample};

  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      sum_r  <= pair_sum;
      mono_r <= pair_mono[etp_pkg::SAMPLE_W:1];
    end
  end

  etp_trk #(
    .ENV_SHIFT (ENV_SHIFT)
  ) u_trk (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .sum_in    (sum_r),
    .trig      (trigger_level_r),
    .atk       (attack_step_r),
    .dcy       (decay_step_r),
    .tune      (tune),
    .phase     (phase),
    .env_level (env_level)
  );

  always_comb begin
    if (whammy_mode_r) begin
      use_val = {1'b0, whammy_amount_r, 8'd0};
    end else if (interval_zero_r) begin
      use_val = prod[etp_pkg::TUNE_W+15:16];
    end else begin
      use_val = tune;
    end
  end

  assign delta = $signed({1'b0, range_ratio_r}) - $signed(19'd65536);

  etp_mul u_mul (
    .clk     (clk),
    .ctl     (ctl),
    .tune    (tune),
    .wamt    (whammy_amount_r),
    .use_val (use_val),
    .delta   (delta),
    .prod    (prod)
  );

  // round half away from zero, then saturate
  assign mag     = prod[etp_pkg::PROD_W-1] ? (~prod + 1'b1) : prod;
  assign mag_rnd = mag + (46'd1 << 23);
  assign q       = mag_rnd[45:24];
  assign ratio   = prod[etp_pkg::PROD_W-1]
                 ? $signed({6'd0, etp_pkg::UNITY_Q16}) - $signed({2'b00, q})
                 : $signed({6'd0, etp_pkg::UNITY_Q16}) + $signed({2'b00, q});

  always_comb begin
    if (ratio < 0) begin
      ratio_sat = '0;
    end else if (ratio > $signed({6'd0, etp_pkg::RATIO_MAX})) begin
      ratio_sat = etp_pkg::RATIO_MAX;
    end else begin
      ratio_sat = ratio[etp_pkg::RATIO_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_mono_r  <= mono_r;
      out_ratio_r <= ratio_sat;
      out_phase_r <= phase;
      out_env_r   <= env_level;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.mono_sample    = out_mono_r;
  assign out_ch.pitch_ratio    = out_ratio_r;
  assign out_ch.ramp_phase     = out_phase_r;
  assign out_ch.envelope_level = out_env_r;

endmodule

`default_nettype wire

[sv/etp_chk.sv]
// ----------------------------------------------------------------------------
// etp_chk
// Port-level checks for the envelope-triggered pitch ramp.
// ----------------------------------------------------------------------------
`default_nettype none

module etp_chk (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [etp_pkg::SAMPLE_W-1:0]  out_mono,
  input wire logic [etp_pkg::RATIO_W-1:0]   out_ratio,
  input wire logic [1:0]                    out_phase,
  input wire logic [etp_pkg::SAMPLE_W-1:0]  out_env
);

  // one item in flight: input closes after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input still open after accept");

  // a new result only appears as the sequencer finishes
  a_result_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while input was open");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_mono) && $stable(out_ratio)
                                && $stable(out_phase) && $stable(out_env))
    else $error("result changed while stalled");

endmodule

bind envelope_triggered_pitch_ramp_unit etp_chk u_etp_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_mono  (out_ch.mono_sample),
  .out_ratio (out_ch.pitch_ratio),
  .out_phase (out_ch.ramp_phase),
  .out_env   (out_ch.envelope_level)
);

`default_nettype wire
